>>> hdl/packet_header_field_extractor_unit_assert.svh
// Assertion macros shared by the header field extractor RTL.
`ifndef PACKET_HEADER_FIELD_EXTRACTOR_UNIT_ASSERT_SVH
`define PACKET_HEADER_FIELD_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PHFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PHFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/phfe_pkg.sv
// Types and constants of the packet header field extractor.
package phfe_pkg;

  // Header sizes and offsets within the frame, in bytes.
  localparam logic [15:0] ETH_LEN      = 16'd14;
  localparam logic [15:0] V4_LEN       = 16'd20;
  localparam logic [15:0] V6_LEN       = 16'd40;
  localparam logic [15:0] TCP_LEN      = 16'd20;
  localparam logic [15:0] UDP_LEN      = 16'd8;
  localparam logic [15:0] OFF_TYPE_HI  = 16'd12;
  localparam logic [15:0] OFF_TYPE_LO  = 16'd13;
  localparam logic [15:0] OFF_V4_IHL   = 16'd14;
  localparam logic [15:0] OFF_V4_TOT_H = 16'd16;
  localparam logic [15:0] OFF_V4_TOT_L = 16'd17;
  localparam logic [15:0] OFF_V6_PAY_H = 16'd18;
  localparam logic [15:0] OFF_V6_PAY_L = 16'd19;
  localparam logic [15:0] OFF_V4_FRAG  = 16'd20;
  localparam logic [15:0] OFF_V6_NXT   = 16'd20;
  localparam logic [15:0] OFF_V4_TTL   = 16'd22;
  localparam logic [15:0] OFF_V4_PROTO = 16'd23;

  // Offsets relative to the start of the layer-4 header.
  localparam logic [15:0] L4_PORTS_END = 16'd4;
  localparam logic [15:0] L4_SEQ_END   = 16'd12;
  localparam logic [15:0] L4_DOFF      = 16'd12;
  localparam logic [15:0] L4_FLAGS     = 16'd13;
  localparam logic [15:0] L4_WIN_H     = 16'd14;
  localparam logic [15:0] L4_WIN_L     = 16'd15;

  localparam logic [15:0] TYPE_ARP  = 16'h0806;
  localparam logic [15:0] TYPE_V4   = 16'h0800;
  localparam logic [15:0] TYPE_V6   = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    L3_NONE = 2'd0,
    L3_ARP  = 2'd1,
    L3_IPV4 = 2'd2,
    L3_IPV6 = 2'd3
  } l3_kind_e;

  // Header fields gathered while a frame streams through.
  typedef struct packed {
    logic [15:0] ether_type;
    logic [5:0]  ip_hdr_len;
    logic [7:0]  ip_proto;
    logic [7:0]  ttl;
    logic [1:0]  frag_bits;
    logic [15:0] tot_len;
    logic [15:0] v6_payload;
    logic [31:0] ports;
    logic [7:0]  ctl_flags;
    logic [15:0] window;
    logic [63:0] seq_ack;
    logic [5:0]  tcp_offset;
  } hdr_state_t;

  // One frame summary word.
  typedef struct packed {
    l3_kind_e    l3_kind;
    logic [7:0]  upper_proto;
    logic [7:0]  ip_ttl;
    logic [5:0]  ip_hdr_bytes;
    logic [1:0]  frag_bits;
    logic [15:0] ip_tot_len;
    logic [31:0] port_pair;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] rx_window;
    logic [63:0] seq_and_ack;
    logic [5:0]  l4_hdr_bytes;
    logic [15:0] payload_bytes;
  } summary_t;

endpackage

>>> hdl/phfe_stream_if.sv
// Valid/ready channel interfaces for frame bytes and frame summaries.
interface phfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface phfe_sum_if;
  logic        valid;
  logic        ready;
  logic [1:0]  l3_kind;
  logic [7:0]  upper_proto;
  logic [7:0]  ip_ttl;
  logic [5:0]  ip_hdr_bytes;
  logic [1:0]  frag_bits;
  logic [15:0] ip_tot_len;
  logic [31:0] port_pair;
  logic [7:0]  tcp_flag_bits;
  logic [15:0] rx_window;
  logic [63:0] seq_and_ack;
  logic [5:0]  l4_hdr_bytes;
  logic [15:0] payload_bytes;

  modport source (
    output valid, input ready,
    output l3_kind, output upper_proto, output ip_ttl, output ip_hdr_bytes, output frag_bits,
    output ip_tot_len, output port_pair, output tcp_flag_bits, output rx_window,
    output seq_and_ack, output l4_hdr_bytes, output payload_bytes
  );
  modport sink (
    input valid, output ready,
    input l3_kind, input upper_proto, input ip_ttl, input ip_hdr_bytes, input frag_bits,
    input ip_tot_len, input port_pair, input tcp_flag_bits, input rx_window,
    input seq_and_ack, input l4_hdr_bytes, input payload_bytes
  );
endinterface

>>> hdl/packet_header_field_extractor_unit.sv
// Ethernet, IPv4/IPv6 and TCP/UDP header field extractor, top level.
//
// A frame enters one word per cycle on byte_i, one byte per word in wire order, with
// frame_end set on the last word. Each byte is held in an input register, then a short
// piece of logic captures it into whichever header field sits at its offset and the
// offset counter moves on; on the last byte the same logic forms the frame summary,
// loads it into the result register and returns all header state to zero, so the next
// frame can follow in the very next cycle. The block sustains one word per cycle; the
// summary is presented on sum_o from the result register once the last byte moves on.
// Only a last byte can be held back, and only while the previous summary still waits in
// the result register, so ordinary bytes keep flowing while the output is stalled. A field
// is reported only when the frame is long enough to hold its whole fixed header
// (Ethernet 14, IPv4 20, IPv6 40, TCP 20, UDP 8 bytes). Bytes beyond MAX_FRAME_BYTES
// are neither counted nor captured, although a last byte there still closes the frame.
// Frames of other ether types, or too short for their layer-3 header, report kind none
// with every field zero; ARP reports its kind and nothing else.
`include "packet_header_field_extractor_unit_assert.svh"

module packet_header_field_extractor_unit import phfe_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  phfe_byte_if.sink     byte_i,
  phfe_sum_if.source    sum_o
);

  // The offset counter only has to reach the frame limit itself.
  localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);

  // Input register.
  logic             in_vld_q, in_vld_d;
  logic [7:0]       in_byte_q;
  logic             in_end_q;

  // Frame state.
  logic [OFF_W-1:0] off_q, off_d;
  hdr_state_t       st_q, st_d, cap;

  // Result register.
  logic             out_vld_q, out_vld_d;
  summary_t         res_q, sum;

  logic             adv;
  logic             load;
  logic [15:0]      off_w;
  logic [15:0]      len_w;
  logic             capture_en;
  logic             is_v4;
  logic             is_v6;
  logic [15:0]      l4_start;
  logic [15:0]      l4_rel;
  logic             in_l4;

  // The held byte moves on unless it closes a frame while the previous summary is
  // still waiting to be taken.
  assign adv  = in_vld_q && (!in_end_q || !out_vld_q || sum_o.ready);
  assign load = adv && in_end_q;

  assign byte_i.ready = !in_vld_q || adv;
  assign in_vld_d     = byte_i.valid ? 1'b1 : (adv ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
      in_end_q  <= byte_i.frame_end;
    end
  end

  // Offset bookkeeping; len_w is the accepted length including the held byte.
  assign off_w      = 16'(off_q);
  assign capture_en = off_w < 16'(MAX_FRAME_BYTES);
  assign len_w      = capture_en ? off_w + 16'd1 : off_w;

  // Field capture for the held byte.
  always_comb begin
    cap = st_q;
    if (off_w == OFF_TYPE_HI || off_w == OFF_TYPE_LO) begin
      cap.ether_type = {st_q.ether_type[7:0], in_byte_q};
    end
    // The IHL nibble takes effect at once: with a tiny IHL the layer-4 header may
    // start on this very byte.
    if (off_w == OFF_V4_IHL) begin
      cap.ip_hdr_len = {in_byte_q[3:0], 2'b00};
    end

    is_v4 = (off_w >= ETH_LEN) && (st_q.ether_type == TYPE_V4);
    is_v6 = (off_w >= ETH_LEN) && (st_q.ether_type == TYPE_V6);

    if (is_v4) begin
      if (off_w == OFF_V4_TOT_H || off_w == OFF_V4_TOT_L) begin
        cap.tot_len = {st_q.tot_len[7:0], in_byte_q};
      end
      // DF and MF sit in the first flags byte; only these two bits are kept and the second
      // flags byte is not captured.
      if (off_w == OFF_V4_FRAG) begin
        cap.frag_bits = in_byte_q[6:5];
      end
      if (off_w == OFF_V4_TTL) begin
        cap.ttl = in_byte_q;
      end
      if (off_w == OFF_V4_PROTO) begin
        cap.ip_proto = in_byte_q;
      end
    end else if (is_v6) begin
      if (off_w == OFF_V6_PAY_H || off_w == OFF_V6_PAY_L) begin
        cap.v6_payload = {st_q.v6_payload[7:0], in_byte_q};
      end
      if (off_w == OFF_V6_NXT) begin
        cap.ip_proto = in_byte_q;
      end
    end

    l4_start = is_v4 ? ETH_LEN + 16'(cap.ip_hdr_len) : ETH_LEN + V6_LEN;
    l4_rel   = off_w - l4_start;
    in_l4    = (is_v4 || is_v6) && (off_w >= l4_start) && (l4_rel < TCP_LEN);

    // The layer-4 fields are gathered whatever the protocol; the summary decides
    // whether they count.
    if (in_l4) begin
      if (l4_rel < L4_PORTS_END) begin
        cap.ports = {st_q.ports[23:0], in_byte_q};
      end else if (l4_rel < L4_SEQ_END) begin
        cap.seq_ack = {st_q.seq_ack[55:0], in_byte_q};
      end else if (l4_rel == L4_DOFF) begin
        cap.tcp_offset = {in_byte_q[7:4], 2'b00};
      end else if (l4_rel == L4_FLAGS) begin
        cap.ctl_flags = in_byte_q;
      end else if (l4_rel == L4_WIN_H || l4_rel == L4_WIN_L) begin
        cap.window = {st_q.window[7:0], in_byte_q};
      end
    end

    // Bytes beyond the frame limit leave the state alone.
    if (!capture_en) begin
      cap = st_q;
    end
  end

  // Frame summary, formed from the state as it stands after the held byte.
  always_comb begin
    logic        ip;
    logic [15:0] l4s;
    logic [16:0] hdr_sum;

    sum     = '0;
    ip      = 1'b0;
    l4s     = 16'd0;
    hdr_sum = 17'd0;

    if (len_w >= ETH_LEN) begin
      if (cap.ether_type == TYPE_ARP) begin
        sum.l3_kind = L3_ARP;
      end else if (cap.ether_type == TYPE_V4 && len_w >= ETH_LEN + V4_LEN) begin
        sum.l3_kind      = L3_IPV4;
        sum.upper_proto  = cap.ip_proto;
        sum.ip_ttl       = cap.ttl;
        sum.ip_hdr_bytes = cap.ip_hdr_len;
        sum.frag_bits    = cap.frag_bits;
        sum.ip_tot_len   = cap.tot_len;
        l4s              = ETH_LEN + 16'(cap.ip_hdr_len);
        ip               = 1'b1;
      end else if (cap.ether_type == TYPE_V6 && len_w >= ETH_LEN + V6_LEN) begin
        sum.l3_kind     = L3_IPV6;
        sum.upper_proto = cap.ip_proto;
        l4s             = ETH_LEN + V6_LEN;
        ip              = 1'b1;
      end
    end

    if (ip) begin
      if (cap.ip_proto == PROTO_TCP && len_w >= l4s + TCP_LEN) begin
        sum.port_pair     = cap.ports;
        sum.tcp_flag_bits = cap.ctl_flags;
        sum.rx_window     = cap.window;
        sum.seq_and_ack   = cap.seq_ack;
        sum.l4_hdr_bytes  = cap.tcp_offset;
      end else if (cap.ip_proto == PROTO_UDP && len_w >= l4s + UDP_LEN) begin
        sum.port_pair    = cap.ports;
        sum.l4_hdr_bytes = 6'(UDP_LEN);
      end

      // IPv4 payload is what the total length leaves after both headers; IPv6
      // reports its own payload length field.
      hdr_sum = 17'(sum.ip_hdr_bytes) + 17'(sum.l4_hdr_bytes);
      if (sum.l3_kind == L3_IPV4) begin
        if (sum.l4_hdr_bytes != 6'd0 && 17'(cap.tot_len) > hdr_sum) begin
          sum.payload_bytes = 16'(17'(cap.tot_len) - hdr_sum);
        end
      end else if (sum.l4_hdr_bytes != 6'd0) begin
        sum.payload_bytes = cap.v6_payload;
      end
    end
  end

  // A closing byte returns the frame state to zero for the next frame.
  always_comb begin
    off_d = off_q;
    st_d  = st_q;
    if (adv) begin
      if (in_end_q) begin
        off_d = '0;
        st_d  = '0;
      end else begin
        off_d = OFF_W'(len_w);
        st_d  = cap;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      st_q  <= '0;
    end else begin
      off_q <= off_d;
      st_q  <= st_d;
    end
  end

  // Result register.
  assign out_vld_d = load ? 1'b1 : (sum_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= sum;
    end
  end

  assign sum_o.valid         = out_vld_q;
  assign sum_o.l3_kind       = res_q.l3_kind;
  assign sum_o.upper_proto   = res_q.upper_proto;
  assign sum_o.ip_ttl        = res_q.ip_ttl;
  assign sum_o.ip_hdr_bytes  = res_q.ip_hdr_bytes;
  assign sum_o.frag_bits     = res_q.frag_bits;
  assign sum_o.ip_tot_len    = res_q.ip_tot_len;
  assign sum_o.port_pair     = res_q.port_pair;
  assign sum_o.tcp_flag_bits = res_q.tcp_flag_bits;
  assign sum_o.rx_window     = res_q.rx_window;
  assign sum_o.seq_and_ack   = res_q.seq_and_ack;
  assign sum_o.l4_hdr_bytes  = res_q.l4_hdr_bytes;
  assign sum_o.payload_bytes = res_q.payload_bytes;

  // A new summary only ever comes from a closing byte.
  `PHFE_ASSERT_NOW(a_sum_from_end, clk_i, rst_ni, $rose(out_vld_q), $past(load),
    "summary appeared without a closing byte")

  // Closing a frame clears the offset for the next one.
  `PHFE_ASSERT_NEXT(a_off_cleared, clk_i, rst_ni, load, off_q == '0,
    "offset not cleared after frame end")

  // The offset never runs past the frame limit.
  `PHFE_ASSERT_NOW(a_off_bound, clk_i, rst_ni, 1'b1, 32'(off_q) <= 32'(MAX_FRAME_BYTES),
    "offset beyond frame limit")

  // Without an IP header there can be no layer-4 fields.
  `PHFE_ASSERT_NOW(a_no_l4_without_ip, clk_i, rst_ni,
    out_vld_q && (res_q.l3_kind == L3_NONE || res_q.l3_kind == L3_ARP),
    res_q.port_pair == '0 && res_q.l4_hdr_bytes == '0 && res_q.payload_bytes == '0,
    "layer-4 fields reported without an IP header")

endmodule
